@@ hw/rtl/lmqs_pkg.sv @@
// Shared types and constants for the local minimum query search block.
// No dependencies; every other file of the block imports this package.
package lmqs_pkg;

  localparam int CFG_W          = 11;
  localparam int VAL_W          = 32;
  localparam int POS_W          = 11;
  localparam int EPOCH_W        = 8;
  localparam int MAX_LENGTH_DEF = 1024;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_REPLY = 1'b1;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MID   = 2'd1;
  localparam logic [1:0] PH_LEFT  = 2'd2;
  localparam logic [1:0] PH_RIGHT = 2'd3;

  typedef struct packed {
    logic             cmd;
    logic [VAL_W-1:0] reply_value;
  } lmqs_in_t;

  typedef struct packed {
    logic             result_kind;
    logic [POS_W-1:0] position;
  } lmqs_out_t;

  // Write enables of the store: tag alone (clear sweep) or tag and value.
  typedef struct packed {
    logic tag_en;
    logic val_en;
  } lmqs_wen_t;

endpackage

@@ hw/rtl/lmqs_store.sv @@
// Value and epoch-tag store of the local minimum search, with a registered read.
// Depends on lmqs_pkg for the write-enable struct and widths.
module lmqs_store #(
  parameter int DEPTH = lmqs_pkg::MAX_LENGTH_DEF,
  parameter int AW    = 10
) (
  input  logic                         clk,
  input  lmqs_pkg::lmqs_wen_t          wen,
  input  logic [AW-1:0]                wr_addr,
  input  logic [lmqs_pkg::EPOCH_W-1:0] wr_tag,
  input  logic [lmqs_pkg::VAL_W-1:0]   wr_val,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [lmqs_pkg::EPOCH_W-1:0] rd_tag,
  output logic [lmqs_pkg::VAL_W-1:0]   rd_val
);
  import lmqs_pkg::*;

  logic [EPOCH_W-1:0] tag_mem [DEPTH];
  logic [VAL_W-1:0]   val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen.tag_en) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    if (wen.val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_tag <= tag_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/local_minimum_query_search.sv @@
// Local minimum search by binary search over an external array.
// Depends on lmqs_pkg and lmqs_store.
//
// Usage: write the array length on the cfg channel (one word, no index), then
// send a start word (cmd = 0) on the in channel. The block answers on the out
// channel with a query word (result_kind = 0, position = p); the user returns
// the array value at p as a reply word (cmd = 1). This repeats until the block
// sends an answer word (result_kind = 1) with the position of a local minimum.
// Each start or reply word gives at most one out word; a reply while no query
// is pending gives none. A start drops any running search.
// A start runs an extra tag wrap sweep over every store entry once every 255 starts.
// Buffering: one word is buffered while the previous one is still at work.
// Reset: a clearing pass writes every tag; in_ready stays low meanwhile,
// while cfg writes are taken as ever.
// A stalled receiver holds the out word; the next word is still buffered and
// processed, and its result waits in the sequencer until the out register frees.
module local_minimum_query_search #(
  parameter int MAX_LENGTH = lmqs_pkg::MAX_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lmqs_pkg::lmqs_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lmqs_pkg::lmqs_out_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lmqs_pkg::CFG_W-1:0] cfg_data
);
  import lmqs_pkg::*;

  // Position width covers 0..MAX_LENGTH+1, store address covers 0..MAX_LENGTH-1.
  localparam int PW = $clog2(MAX_LENGTH + 2);
  localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_WAIT  = 4'd1;
  localparam logic [3:0] S_MID   = 4'd2;
  localparam logic [3:0] S_RM    = 4'd3;
  localparam logic [3:0] S_CM    = 4'd4;
  localparam logic [3:0] S_CL    = 4'd5;
  localparam logic [3:0] S_CR    = 4'd6;
  localparam logic [3:0] S_EVAL  = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_len_r;
  logic               buf_valid_r, buf_valid_nxt;
  lmqs_in_t           buf_r;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               clr_start_r, clr_start_nxt;
  logic [PW-1:0]      low_r, low_nxt;
  logic [PW-1:0]      high_r, high_nxt;
  logic [PW-1:0]      mid_r, mid_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [VAL_W-1:0]   vm_r, vm_nxt;
  logic [VAL_W-1:0]   vl_r, vl_nxt;
  logic [VAL_W-1:0]   vr_r, vr_nxt;
  lmqs_out_t          pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  lmqs_out_t          out_data_r, out_data_nxt;

  logic [CW-1:0]      cfg_ext;
  logic [PW-1:0]      len_eff;
  logic               left_inf, right_inf, known;
  logic [PW-1:0]      wr_pos;
  lmqs_wen_t          wen;
  logic [AW-1:0]      wr_addr;
  logic [EPOCH_W-1:0] wr_tag;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [EPOCH_W-1:0] rd_tag;
  logic [VAL_W-1:0]   rd_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = !buf_valid_r && (state_r != S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the length register into 1..MAX_LENGTH.
  assign cfg_ext = CW'(cfg_len_r);
  always_comb begin
    if (cfg_len_r == '0) begin
      len_eff = PW'(1);
    end else if (cfg_ext > CW'(MAX_LENGTH)) begin
      len_eff = PW'(MAX_LENGTH);
    end else begin
      len_eff = PW'(cfg_ext);
    end
  end

  // Neighbors outside 1..length count as infinite.
  assign left_inf  = (mid_r <= PW'(1));
  assign right_inf = (mid_r >= len_eff);
  // An entry is known when its tag carries the current search's epoch.
  assign known     = (rd_tag == epoch_r);

  // Position that the pending reply belongs to.
  always_comb begin
    unique case (phase_r)
      PH_LEFT:  wr_pos = mid_r - PW'(1);
      PH_RIGHT: wr_pos = mid_r + PW'(1);
      default:  wr_pos = mid_r;
    endcase
  end

  lmqs_store #(
    .DEPTH (MAX_LENGTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wen     (wen),
    .wr_addr (wr_addr),
    .wr_tag  (wr_tag),
    .wr_val  (buf_r.reply_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_tag  (rd_tag),
    .rd_val  (rd_val)
  );

  always_comb begin
    state_nxt     = state_r;
    buf_valid_nxt = buf_valid_r;
    epoch_nxt     = epoch_r;
    clr_addr_nxt  = clr_addr_r;
    clr_start_nxt = clr_start_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    mid_nxt       = mid_r;
    phase_nxt     = phase_r;
    vm_nxt        = vm_r;
    vl_nxt        = vl_r;
    vr_nxt        = vr_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wen           = '0;
    wr_addr       = AW'(wr_pos - PW'(1));
    wr_tag        = epoch_r;
    rd_en         = 1'b0;
    rd_addr       = AW'(mid_r - PW'(1));

    // Drop the out word once taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    // Hold one incoming word.
    if (in_valid && in_ready) begin
      buf_valid_nxt = 1'b1;
    end

    unique case (state_r)
      S_CLEAR: begin
        wen.tag_en = 1'b1;
        wr_addr    = clr_addr_r;
        wr_tag     = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_LENGTH - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = clr_start_r ? S_MID : S_WAIT;
        end
      end
      S_WAIT: begin
        if (buf_valid_r) begin
          buf_valid_nxt = 1'b0;
          if (buf_r.cmd == CMD_START) begin
            low_nxt  = PW'(1);
            high_nxt = len_eff;
            if (epoch_r == '1) begin
              // Tag wrap: sweep stale tags before the new epoch starts.
              epoch_nxt     = EPOCH_W'(1);
              clr_start_nxt = 1'b1;
              state_nxt     = S_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
              state_nxt = S_MID;
            end
          end else if (phase_r != PH_IDLE) begin
            wen.tag_en = 1'b1;
            wen.val_en = 1'b1;
            state_nxt  = S_RM;
          end
        end
      end
      S_MID: begin
        mid_nxt   = low_r + ((high_r - low_r) >> 1);
        state_nxt = S_RM;
      end
      S_RM: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(mid_r - PW'(1));
        state_nxt = S_CM;
      end
      S_CM: begin
        if (!known) begin
          pend_nxt  = '{result_kind: KIND_QUERY, position: POS_W'(mid_r)};
          phase_nxt = PH_MID;
          state_nxt = S_EMIT;
        end else begin
          vm_nxt = rd_val;
          if (!left_inf) begin
            rd_en     = 1'b1;
            rd_addr   = AW'(mid_r - PW'(2));
            state_nxt = S_CL;
          end else if (!right_inf) begin
            rd_en     = 1'b1;
            rd_addr   = AW'(mid_r);
            state_nxt = S_CR;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_CL: begin
        if (!known) begin
          pend_nxt  = '{result_kind: KIND_QUERY, position: POS_W'(mid_r - PW'(1))};
          phase_nxt = PH_LEFT;
          state_nxt = S_EMIT;
        end else begin
          vl_nxt = rd_val;
          if (!right_inf) begin
            rd_en     = 1'b1;
            rd_addr   = AW'(mid_r);
            state_nxt = S_CR;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_CR: begin
        if (!known) begin
          pend_nxt  = '{result_kind: KIND_QUERY, position: POS_W'(mid_r + PW'(1))};
          phase_nxt = PH_RIGHT;
          state_nxt = S_EMIT;
        end else begin
          vr_nxt    = rd_val;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        pend_nxt = '{result_kind: KIND_ANSWER, position: POS_W'(mid_r)};
        priority if ((left_inf || vl_r > vm_r) && (right_inf || vr_r > vm_r)) begin
          phase_nxt = PH_IDLE;
          state_nxt = S_EMIT;
        end else if (!left_inf && vl_r < vm_r) begin
          // Narrow left; an empty range means the midpoint is the answer.
          if (mid_r <= low_r) begin
            phase_nxt = PH_IDLE;
            state_nxt = S_EMIT;
          end else begin
            high_nxt  = mid_r - PW'(1);
            state_nxt = S_MID;
          end
        end else begin
          if (mid_r >= high_r) begin
            phase_nxt = PH_IDLE;
            state_nxt = S_EMIT;
          end else begin
            low_nxt   = mid_r + PW'(1);
            state_nxt = S_MID;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_r;
          state_nxt     = S_WAIT;
        end
      end
      default: begin
        state_nxt = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cfg_len_r   <= CFG_W'(1);
      buf_valid_r <= 1'b0;
      epoch_r     <= '0;
      clr_addr_r  <= '0;
      clr_start_r <= 1'b0;
      low_r       <= PW'(1);
      high_r      <= PW'(1);
      mid_r       <= '0;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      buf_valid_r <= buf_valid_nxt;
      epoch_r     <= epoch_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_start_r <= clr_start_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      mid_r       <= mid_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_len_r <= cfg_data;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_r <= in_data;
    end
    vm_r       <= vm_nxt;
    vl_r       <= vl_nxt;
    vr_r       <= vr_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ tb/local_minimum_query_search_tb.sv @@
// Self-checking bench for local_minimum_query_search: a built-in search model plays
// the array oracle and predicts every query and answer word the block should send.
// Depends on lmqs_pkg and the local_minimum_query_search RTL.
module local_minimum_query_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmqs_pkg::*;

  localparam int LEN_MAX       = MAX_LENGTH_DEF;
  localparam int ITEM_TARGET   = 1600;   // words that cause an out word
  localparam int CALM_AFTER    = 1400;   // no idling past this point
  localparam int SETTLE_CYCLES = 40;     // quiet time before a cfg write and at the end
  localparam int REPORT_LIMIT  = 10;
  localparam int SHAPE_COUNT   = 7;

  // Array shapes the oracle answers with; each one steers the search differently.
  typedef enum int {
    SHAPE_NOISE,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_FLAT,
    SHAPE_COARSE,
    SHAPE_VALLEY,
    SHAPE_EXTREME
  } shape_e;

  // One staged in word together with the out word it should cause.
  typedef struct packed {
    lmqs_in_t  word;
    logic      yields;
    lmqs_out_t outcome;
  } staged_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  lmqs_in_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  lmqs_out_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data  = '0;

  staged_t     word_backlog[$];    // in words not yet accepted
  lmqs_out_t   awaited_words[$];   // out words owed by accepted in words
  lmqs_out_t   due_word;
  int unsigned mismatch_count  = 0;
  int unsigned staged_results  = 0;
  int unsigned idle_pct        = 0;
  bit          calm            = 1'b0;
  int unsigned in_gap          = 0;
  int unsigned out_gap         = 0;

  // Search model state: what the block should know about the array.
  logic [VAL_W-1:0]   seen_value [0:LEN_MAX+1];
  logic [LEN_MAX+1:0] seen_mark;
  int unsigned        span_low;
  int unsigned        span_high;
  int unsigned        probe;
  logic [1:0]         await_phase;
  logic [CFG_W-1:0]   length_reg;

  // Oracle state for the array currently being searched.
  shape_e           shape;
  int unsigned      valley_at;
  logic [VAL_W-1:0] flat_level;

  local_minimum_query_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Zero reads as one position, anything past the top as the full array.
  function automatic int unsigned live_length();
    int unsigned n;
    n = length_reg;
    if (n < 1) n = 1;
    if (n > LEN_MAX) n = LEN_MAX;
    return n;
  endfunction

  // Walk midpoints until a position is still unknown (query it) or a minimum
  // is settled (answer it). Edges 0 and length+1 count as infinite.
  function automatic lmqs_out_t seek_minimum();
    int unsigned n;
    int unsigned m;
    bit          left_edge;
    bit          right_edge;
    bit          settled;
    bit          found;
    lmqs_out_t   r;
    n       = live_length();
    settled = 1'b0;
    r       = '0;
    while (!settled) begin
      m          = probe;
      left_edge  = (m <= 1);
      right_edge = (m >= n);
      settled    = 1'b1;
      found      = 1'b0;
      if (!seen_mark[m]) begin
        await_phase = PH_MID;
        r = {KIND_QUERY, POS_W'(m)};
      end else if (!left_edge && !seen_mark[m-1]) begin
        await_phase = PH_LEFT;
        r = {KIND_QUERY, POS_W'(m - 1)};
      end else if (!right_edge && !seen_mark[m+1]) begin
        await_phase = PH_RIGHT;
        r = {KIND_QUERY, POS_W'(m + 1)};
      end else if ((left_edge || seen_value[m-1] > seen_value[m]) &&
                   (right_edge || seen_value[m+1] > seen_value[m])) begin
        found = 1'b1;
      end else if (!left_edge && seen_value[m-1] < seen_value[m]) begin
        // narrow left; nothing left of the range means the midpoint wins
        if (m <= span_low) found = 1'b1;
        else begin
          span_high = m - 1;
          settled   = 1'b0;
        end
      end else begin
        // narrow right, with the same tie rule at the top of the range
        if (m >= span_high) found = 1'b1;
        else begin
          span_low = m + 1;
          settled  = 1'b0;
        end
      end
      if (found) begin
        await_phase = PH_IDLE;
        r = {KIND_ANSWER, POS_W'(m)};
      end
      if (!settled) probe = span_low + (span_high - span_low) / 2;
    end
    return r;
  endfunction

  // Advance the search model by one in word; returns 1 when an out word is due.
  function automatic bit search_step(input lmqs_in_t w, output lmqs_out_t r);
    int unsigned pos;
    r = '0;
    if (w.cmd == CMD_START) begin
      seen_mark = '0;
      span_low  = 1;
      span_high = live_length();
      probe     = span_low + (span_high - span_low) / 2;
      r = seek_minimum();
      return 1'b1;
    end
    if (await_phase == PH_IDLE) return 1'b0;
    case (await_phase)
      PH_MID:  pos = probe;
      PH_LEFT: pos = probe - 1;
      default: pos = probe + 1;
    endcase
    if (pos > LEN_MAX + 1) pos = LEN_MAX + 1;
    seen_value[pos] = w.reply_value;
    seen_mark[pos]  = 1'b1;
    r = seek_minimum();
    return 1'b1;
  endfunction

  // Value the oracle returns for a queried position.
  function automatic logic [VAL_W-1:0] array_value(input int unsigned pos);
    int unsigned offset;
    offset = (pos > valley_at) ? pos - valley_at : valley_at - pos;
    case (shape)
      SHAPE_RISING:  return VAL_W'(pos);
      SHAPE_FALLING: return {VAL_W{1'b1}} - VAL_W'(pos);
      SHAPE_FLAT:    return flat_level;
      SHAPE_COARSE:  return VAL_W'($urandom_range(0, 2));
      SHAPE_VALLEY:  return VAL_W'(offset / 2);   // halve to get plateaus
      SHAPE_EXTREME: return ($urandom_range(0, 1) != 0) ? {VAL_W{1'b1}} : '0;
      default:       return $urandom;
    endcase
  endfunction

  // Queue one in word and record what it should cause.
  task automatic stage_word(input logic cmd, input logic [VAL_W-1:0] value,
                            output lmqs_out_t r, output bit yields);
    staged_t s;
    s.word.cmd         = cmd;
    s.word.reply_value = value;
    yields             = search_step(s.word, r);
    s.yields           = yields;
    s.outcome          = r;
    word_backlog       = {word_backlog, s};
    if (yields) staged_results++;
  endtask

  // Run one search to its answer, answering each query from the chosen shape.
  // With upset_pct > 0 the search may be restarted or simply abandoned.
  task automatic run_search(input shape_e kind, input int unsigned upset_pct);
    lmqs_out_t   r;
    bit          y;
    bit          dropped;
    int unsigned roll;
    shape      = kind;
    flat_level = $urandom;
    valley_at  = $urandom_range(1, live_length());
    dropped    = 1'b0;
    stage_word(CMD_START, $urandom, r, y);
    while (r.result_kind == KIND_QUERY && !dropped) begin
      roll = $urandom_range(0, 99);
      if (roll < upset_pct) stage_word(CMD_START, $urandom, r, y);
      else if (roll < 2 * upset_pct) dropped = 1'b1;
      else stage_word(CMD_REPLY, array_value(r.position), r, y);
    end
    // stray reply: ignored when idle, a real reply when the search was dropped
    if ($urandom_range(0, 99) < 15) stage_word(CMD_REPLY, $urandom, r, y);
  endtask

  // Hold cfg_valid until the length word is taken, then update the model.
  task automatic write_length(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    length_reg = value;
  endtask

  // Wait until every staged word is accepted and every owed word has come,
  // then give a stray ignored reply time to finish inside the block.
  task automatic drain();
    while (word_backlog.size() != 0 || awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic flag_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  // Driver: hold the word until accepted, then move its expectation over and
  // either idle for a burst or present the next word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   = 0;
    end else if (in_valid && !in_ready) begin
      // hold valid and payload
    end else begin
      if (in_valid) begin
        if (word_backlog[0].yields) awaited_words = {awaited_words, word_backlog[0].outcome};
        void'(word_backlog.pop_front());
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        in_gap = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (word_backlog.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= word_backlog[0].word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted out word against the oldest owed word,
  // field by field, and stall the out channel in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          flag_failure($sformatf("unexpected out word kind=%0d pos=%0d",
                                 out_data.result_kind, out_data.position));
        end else begin
          due_word = awaited_words.pop_front();
          if (out_data.result_kind !== due_word.result_kind)
            flag_failure($sformatf("result_kind: expected %0d, got %0d",
                                   due_word.result_kind, out_data.result_kind));
          if (out_data.position !== due_word.position)
            flag_failure($sformatf("position: expected %0d, got %0d",
                                   due_word.position, out_data.position));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        out_gap = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed searches first, then random phases, each phase opened
  // by a length write once the block has gone quiet.
  initial begin
    lmqs_out_t   r;
    bit          y;
    int unsigned phase_no;
    int unsigned roll;
    seen_mark   = '0;
    span_low    = 1;
    span_high   = 1;
    probe       = 0;
    await_phase = PH_IDLE;
    length_reg  = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Zero length acts as one position; stray replies around it are ignored.
    write_length('0);
    @(negedge clk);
    stage_word(CMD_REPLY, {VAL_W{1'b1}}, r, y);
    stage_word(CMD_START, '0, r, y);
    stage_word(CMD_REPLY, '0, r, y);
    stage_word(CMD_REPLY, '0, r, y);
    drain();

    // Three positions: all-equal values force the tie answer; then drop a
    // running search with a fresh start.
    idle_pct = 30;
    write_length(CFG_W'(3));
    @(negedge clk);
    run_search(SHAPE_FLAT, 0);
    stage_word(CMD_START, '0, r, y);
    stage_word(CMD_REPLY, 32'd5, r, y);
    run_search(SHAPE_VALLEY, 0);
    drain();

    // Two positions: minimum at either edge.
    write_length(CFG_W'(2));
    @(negedge clk);
    run_search(SHAPE_FALLING, 0);
    run_search(SHAPE_RISING, 0);

    phase_no = 0;
    while (staged_results < ITEM_TARGET) begin
      drain();
      if (staged_results >= CALM_AFTER) calm = 1'b1;
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      // open with the length extremes, then mostly short arrays
      case (phase_no)
        0: write_length(CFG_W'(LEN_MAX));
        1: write_length({CFG_W{1'b1}});
        2: write_length(CFG_W'(LEN_MAX + 1));
        3: write_length(CFG_W'(1));
        4: write_length('0);
        default: begin
          roll = $urandom_range(0, 99);
          if (roll < 60) write_length(CFG_W'($urandom_range(1, 16)));
          else if (roll < 85) write_length(CFG_W'($urandom_range(17, 200)));
          else write_length(CFG_W'($urandom_range(201, (1 << CFG_W) - 1)));
        end
      endcase
      @(negedge clk);
      repeat ($urandom_range(1, 6)) run_search(shape_e'($urandom_range(0, SHAPE_COUNT - 1)), 3);
      phase_no++;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
